@@ src/mat4mul_pkg.sv @@
// shared types and constants of the 4x4 fixed-point matrix multiplier
package mat4mul_pkg;

    // matrix geometry
    localparam int DIM   = 4;
    localparam int CELLS = DIM * DIM;
    localparam int IDX_W = $clog2(CELLS);

    // one element takes two half-width products per term, four terms
    localparam int STEP_W = IDX_W + $clog2(DIM) + 1;
    localparam logic [STEP_W-1:0] STEP_LAST = {STEP_W{1'b1}};

    // request kinds
    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD_A   = 2'd0;
    localparam t_op OP_LOAD_B   = 2'd1;
    localparam t_op OP_MULTIPLY = 2'd2;

    // control tag that follows each partial product down the datapath
    typedef struct packed {
        logic             first;
        logic             last;
        logic             half;
        logic [IDX_W-1:0] elem;
    } t_tag;

endpackage

@@ src/mat4mul_store.sv @@
// matrix storage, step sequencer and operand fetch of the matrix multiplier
module mat4mul_store #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_accept,
    input  mat4mul_pkg::t_op              i_op,
    input  logic [1:0]                    i_row,
    input  logic [1:0]                    i_col,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_busy,
    output logic                          o_valid,
    output mat4mul_pkg::t_tag             o_tag,
    output logic signed [VALUE_WIDTH-1:0] o_a,
    output logic signed [VALUE_WIDTH-1:0] o_b
);
    import mat4mul_pkg::*;

    logic signed [VALUE_WIDTH-1:0] r_left  [CELLS];
    logic signed [VALUE_WIDTH-1:0] r_right [CELLS];

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              r_valid;
    t_tag              r_tag;
    t_tag              n_tag;
    logic signed [VALUE_WIDTH-1:0] r_a;
    logic signed [VALUE_WIDTH-1:0] r_b;

    logic [1:0]       step_i;
    logic [1:0]       step_j;
    logic [1:0]       step_k;
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;

    // step decode: element, term, half of the right operand
    assign step_i = r_step[STEP_W-1 -: 2];
    assign step_j = r_step[STEP_W-3 -: 2];
    assign step_k = r_step[2:1];
    assign a_idx  = {step_i, step_k};
    assign b_idx  = {step_k, step_j};

    always_comb begin
        n_tag.elem  = r_step[STEP_W-1 -: IDX_W];
        n_tag.half  = r_step[0];
        n_tag.first = (step_k == 2'd0) && !r_step[0];
        n_tag.last  = (step_k == 2'(DIM - 1)) && r_step[0];
    end

    // element writes
    always_ff @(posedge i_clk) begin
        if (i_accept && (i_op == OP_LOAD_A)) begin
            r_left[{i_row, i_col}] <= i_value;
        end
        if (i_accept && (i_op == OP_LOAD_B)) begin
            r_right[{i_row, i_col}] <= i_value;
        end
    end

    // operand fetch for the step being issued
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= r_left[a_idx];
            r_b   <= r_right[b_idx];
            r_tag <= n_tag;
        end
    end

    // sequencer: a multiply request walks all steps once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_en) begin
                r_valid <= r_busy;
            end
            if (i_accept && (i_op == OP_MULTIPLY)) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy && i_en) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_a     = r_a;
    assign o_b     = r_b;

    // the sequencer only goes idle after the final step
    a_busy_ends_on_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> ($past(r_step) == STEP_LAST))
        else $error("sequencer left busy before the final step");

endmodule

@@ src/mat4mul_mac.sv @@
// shared multiplier, accumulator and saturation of the matrix multiplier
module mat4mul_mac #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_en,
    input  logic                                     i_valid,
    input  mat4mul_pkg::t_tag                        i_tag,
    input  logic signed [VALUE_WIDTH-1:0]            i_a,
    input  logic signed [VALUE_WIDTH-1:0]            i_b,
    output logic                                     o_done,
    output logic [mat4mul_pkg::IDX_W-1:0]            o_elem,
    output logic [VALUE_WIDTH-1:0]                   o_value,
    output logic                                     o_overflow
);
    import mat4mul_pkg::*;

    // right operand is split into an unsigned low half and a signed high half
    localparam int HALF_W = (VALUE_WIDTH + 1) / 2;
    localparam int HIGH_W = VALUE_WIDTH - HALF_W;
    localparam int BOP_W  = HALF_W + 1;
    localparam int PROD_W = VALUE_WIDTH + BOP_W;
    localparam int ACC_W  = 2 * VALUE_WIDTH + 2;
    localparam logic [VALUE_WIDTH-1:0] MAX_VAL = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    logic signed [HIGH_W-1:0] b_high;
    logic signed [BOP_W-1:0]  b_high_ext;
    logic signed [BOP_W-1:0]  b_low_ext;
    logic signed [BOP_W-1:0]  b_op;

    logic                     r_v2;
    t_tag                     r_tag2;
    logic signed [PROD_W-1:0] r_prod;

    logic                     r_v3;
    t_tag                     r_tag3;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  addend;
    logic signed [ACC_W-1:0]  n_acc;

    logic signed [ACC_W-1:0]           shifted;
    logic [ACC_W-VALUE_WIDTH:0]        upper;
    logic                              fits;

    // half select of the right operand
    assign b_high     = i_b[VALUE_WIDTH-1:HALF_W];
    assign b_high_ext = BOP_W'(b_high);
    assign b_low_ext  = {1'b0, i_b[HALF_W-1:0]};
    assign b_op       = i_tag.half ? b_high_ext : b_low_ext;

    // weight the high half and accumulate over the four terms
    assign prod_ext = ACC_W'(r_prod);
    assign addend   = r_tag2.half ? (prod_ext <<< HALF_W) : prod_ext;
    assign n_acc    = (r_tag2.first ? ACC_W'(0) : r_acc) + addend;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(b_op);
            r_tag2 <= i_tag;
            r_tag3 <= r_tag2;
            if (r_v2) begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    // scale back and clamp to the element range
    assign shifted = r_acc >>> FRAC_BITS;
    assign upper   = shifted[ACC_W-1:VALUE_WIDTH-1];
    assign fits    = (&upper) || !(|upper);

    assign o_done     = r_v3 && r_tag3.last;
    assign o_elem     = r_tag3.elem;
    assign o_value    = fits ? shifted[VALUE_WIDTH-1:0]
                             : (shifted[ACC_W-1] ? ~MAX_VAL : MAX_VAL);
    assign o_overflow = !fits;

    // a stalled datapath must not disturb a running sum
    a_acc_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !i_en) |=> $stable(r_acc))
        else $error("accumulator changed while stalled");

endmodule

@@ src/matrix4x4_multiply.sv @@
// top level of the 4x4 signed fixed-point matrix multiplier
//
// A load request (tuser 0 for A, 1 for B) writes one element. A multiply
// request (tuser 2) holds the input side not ready while the sequencer walks
// its steps: each of the 16 product elements needs four terms, and each term
// goes through the single shared multiplier as two half-width partial
// products. Each result passes the operand fetch, product, accumulator and
// output registers, and results leave in row-major order, tlast on row 3
// column 3. A stalled output stalls the whole datapath. Results are the exact
// sum shifted right by FRAC_BITS (rounding towards minus infinity) and
// saturated, with tuser set when saturation happened. Code 3 is ignored.
// Elements must be written before a multiply reads them.
module matrix4x4_multiply #(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_s_axis_tvalid,
    output logic                                      o_s_axis_tready,
    // row[1:0], col[3:2], value, zero fill
    input  logic [((VALUE_WIDTH+4+7)/8)*8-1:0]        i_s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                                i_s_axis_tuser,
    output logic                                      o_m_axis_tvalid,
    input  logic                                      i_m_axis_tready,
    // out_row[1:0], out_col[3:2], out_value, zero fill
    output logic [((VALUE_WIDTH+4+7)/8)*8-1:0]        o_m_axis_tdata,
    // overflow
    output logic                                      o_m_axis_tuser,
    output logic                                      o_m_axis_tlast
);
    import mat4mul_pkg::*;

    localparam int TDATA_W = ((VALUE_WIDTH + 4 + 7) / 8) * 8;
    localparam logic [IDX_W-1:0] ELEM_LAST = IDX_W'(CELLS - 1);

    logic                          accept;
    logic                          en;
    logic                          busy;
    logic                          fetch_valid;
    t_tag                          fetch_tag;
    logic signed [VALUE_WIDTH-1:0] fetch_a;
    logic signed [VALUE_WIDTH-1:0] fetch_b;
    logic                          mac_done;
    logic [IDX_W-1:0]              mac_elem;
    logic [VALUE_WIDTH-1:0]        mac_value;
    logic                          mac_overflow;

    logic                          r_out_valid;
    logic [IDX_W-1:0]              r_elem;
    logic [VALUE_WIDTH-1:0]        r_value;
    logic                          r_overflow;

    // request handshake and datapath advance
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = !busy;
    assign en              = !r_out_valid || i_m_axis_tready;

    mat4mul_store #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_accept (accept),
        .i_op     (i_s_axis_tuser),
        .i_row    (i_s_axis_tdata[1:0]),
        .i_col    (i_s_axis_tdata[3:2]),
        .i_value  (i_s_axis_tdata[4 +: VALUE_WIDTH]),
        .o_busy   (busy),
        .o_valid  (fetch_valid),
        .o_tag    (fetch_tag),
        .o_a      (fetch_a),
        .o_b      (fetch_b)
    );

    mat4mul_mac #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (fetch_valid),
        .i_tag      (fetch_tag),
        .i_a        (fetch_a),
        .i_b        (fetch_b),
        .o_done     (mac_done),
        .o_elem     (mac_elem),
        .o_value    (mac_value),
        .o_overflow (mac_overflow)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= mac_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && mac_done) begin
            r_elem     <= mac_elem;
            r_value    <= mac_value;
            r_overflow <= mac_overflow;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = TDATA_W'({r_value, r_elem[1:0], r_elem[3:2]});
    assign o_m_axis_tuser  = r_overflow;
    assign o_m_axis_tlast  = (r_elem == ELEM_LAST);

    // tlast only ever marks the bottom-right element
    a_last_is_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            (o_m_axis_tdata[1:0] == 2'(DIM - 1)) && (o_m_axis_tdata[3:2] == 2'(DIM - 1)))
        else $error("tlast on an element other than the last");

    // a multiply request closes the input side straight away
    a_multiply_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_s_axis_tuser == OP_MULTIPLY)) |=> !o_s_axis_tready)
        else $error("input ready while a multiply is running");

endmodule

@@ test/tb_matrix4x4_multiply.sv @@
// self-checking testbench for the 4x4 fixed-point matrix multiplier
`timescale 1ns / 100ps

module tb_matrix4x4_multiply;
    import mat4mul_pkg::*;

    localparam int VW         = 32;
    localparam int FB         = 16;
    localparam int DW         = ((VW + 4 + 7) / 8) * 8;
    localparam int STALL_MAX  = 3000;
    localparam int HOLD_LEN   = 400;
    localparam int HOLD_START = 2500;
    localparam int CALM_FROM  = 4000;
    localparam int CALM_TO    = 6000;
    localparam int RAND_ITEMS = 422;
    localparam t_op OP_UNUSED = 2'd3;
    localparam longint VMAX   = 64'sd2147483647;
    localparam longint VMIN   = -64'sd2147483648;

    // one request waiting for the driver, or a marker to wait for the drain
    typedef struct {
        t_op         op;
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        bit          drain;
    } request_t;

    // one product element as it should leave the block
    typedef struct packed {
        logic [1:0]  row;
        logic [1:0]  col;
        logic [31:0] value;
        logic        ovf;
        logic        last;
    } product_t;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_valid = 1'b0;
    logic [DW-1:0] s_data = '0;
    logic [1:0]    s_user = 2'd0;
    logic          m_ready = 1'b0;
    logic          o_s_axis_tready;
    logic          o_m_axis_tvalid;
    logic [DW-1:0] o_m_axis_tdata;
    logic          o_m_axis_tuser;
    logic          o_m_axis_tlast;

    request_t pending_requests[$];
    product_t expected_products[$];
    request_t next_req;

    logic signed [VW-1:0] left_elem [CELLS];
    logic signed [VW-1:0] right_elem [CELLS];

    int  errors = 0;
    int  cycle = 0;
    int  stall_cycles = 0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;
    bit  in_taken = 1'b0;
    bit  calm;

    matrix4x4_multiply #(
        .VALUE_WIDTH(VW),
        .FRAC_BITS  (FB)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    // clock
    always #5 i_clk = ~i_clk;

    assign calm = (cycle >= CALM_FROM) && (cycle < CALM_TO);

    // queue one request
    task automatic add_request(t_op op, logic [1:0] row, logic [1:0] col, logic [31:0] value);
        request_t r;
        r.op    = op;
        r.row   = row;
        r.col   = col;
        r.value = value;
        r.drain = 1'b0;
        pending_requests.push_back(r);
    endtask

    // one line per mismatch, counted
    task automatic report_mismatch(string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycle, what);
    endtask

    // all sixteen elements of A times B, shifted and saturated
    task automatic predict_product();
        logic signed [65:0] acc;
        logic signed [65:0] pa;
        logic signed [65:0] pb;
        logic signed [65:0] shifted;
        product_t p;
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                acc = '0;
                for (int k = 0; k < DIM; k++) begin
                    pa  = left_elem[i*DIM + k];
                    pb  = right_elem[k*DIM + j];
                    acc = acc + pa * pb;
                end
                shifted = acc >>> FB;
                p.row   = i[1:0];
                p.col   = j[1:0];
                p.last  = (i == DIM - 1) && (j == DIM - 1);
                if (shifted > VMAX) begin
                    p.value = 32'h7FFF_FFFF;
                    p.ovf   = 1'b1;
                end else if (shifted < VMIN) begin
                    p.value = 32'h8000_0000;
                    p.ovf   = 1'b1;
                end else begin
                    p.value = shifted[31:0];
                    p.ovf   = 1'b0;
                end
                expected_products.push_back(p);
            end
        end
    endtask

    // accepted request updates the matrices or yields a product
    task automatic apply_request(t_op op, logic [DW-1:0] data);
        logic [3:0] idx;
        idx = {data[1:0], data[3:2]};
        case (op)
            OP_LOAD_A:   left_elem[idx] = data[35:4];
            OP_LOAD_B:   right_elem[idx] = data[35:4];
            OP_MULTIPLY: predict_product();
            default: ;
        endcase
    endtask

    // compare each result with the oldest expectation, then take the input
    always @(posedge i_clk) begin
        product_t want;
        cycle    <= cycle + 1;
        in_taken <= i_rst_n && s_valid && o_s_axis_tready;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                if (expected_products.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = expected_products.pop_front();
                    if (o_m_axis_tdata[1:0] !== want.row)
                        report_mismatch($sformatf("row %0d, want %0d",
                            o_m_axis_tdata[1:0], want.row));
                    if (o_m_axis_tdata[3:2] !== want.col)
                        report_mismatch($sformatf("col %0d, want %0d",
                            o_m_axis_tdata[3:2], want.col));
                    if (o_m_axis_tdata[35:4] !== want.value)
                        report_mismatch($sformatf("value %h, want %h at %0d,%0d",
                            o_m_axis_tdata[35:4], want.value, want.row, want.col));
                    if (o_m_axis_tdata[DW-1:36] !== '0)
                        report_mismatch("fill bits not zero");
                    if (o_m_axis_tuser !== want.ovf)
                        report_mismatch($sformatf("overflow %b, want %b at %0d,%0d",
                            o_m_axis_tuser, want.ovf, want.row, want.col));
                    if (o_m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last %b, want %b at %0d,%0d",
                            o_m_axis_tlast, want.last, want.row, want.col));
                end
            end
            if (s_valid && o_s_axis_tready)
                apply_request(s_user, s_data);
        end
    end

    // request driver, with random gaps and a pause for the drain marker
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_requests.size() != 0 && pending_requests[0].drain) begin
                if (expected_products.size() == 0)
                    void'(pending_requests.pop_front());
                s_valid <= 1'b0;
            end else if (pending_requests.size() == 0 ||
                         (!calm && $urandom_range(99) < 19)) begin
                s_valid <= 1'b0;
            end else begin
                next_req = pending_requests.pop_front();
                s_valid <= 1'b1;
                s_data  <= {{(DW-36){1'b0}}, next_req.value, next_req.col, next_req.row};
                s_user  <= next_req.op;
            end
        end
    end

    // result receiver, with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready  <= 1'b0;
        end else if (!hold_done && cycle >= HOLD_START && o_m_axis_tvalid) begin
            hold_cnt  <= HOLD_LEN;
            hold_done <= 1'b1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(99) >= 19);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX) begin
            $display("watchdog expired at cycle %0d", cycle);
            $display("** matrix4x4_multiply: FAILED **");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        logic [31:0] row_val [4];
        logic [31:0] col_val [4];
        logic [31:0] v;
        logic [31:0] r;
        request_t    marker;
        int          pick;

        for (int i = 0; i < CELLS; i++) begin
            left_elem[i]  = '0;
            right_elem[i] = '0;
        end

        // directed: rows of A and columns of B at fixed values, among them the extremes
        row_val = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_8000};
        col_val = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++)
                add_request(OP_LOAD_A, i[1:0], j[1:0], row_val[i]);
        for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++)
                add_request(OP_LOAD_B, i[1:0], j[1:0], col_val[j]);
        add_request(OP_MULTIPLY, 2'd0, 2'd0, 32'h0000_0000);
        // unused code must change nothing
        add_request(OP_UNUSED, 2'd3, 2'd3, 32'hFFFF_FFFF);
        // position and value on a multiply are ignored
        add_request(OP_MULTIPLY, 2'd3, 2'd2, 32'hA5A5_5A5A);
        add_request(OP_LOAD_A, 2'd0, 2'd0, 32'h0000_0000);
        add_request(OP_LOAD_B, 2'd3, 2'd3, 32'h0001_0000);
        add_request(OP_MULTIPLY, 2'd1, 2'd1, 32'hFFFF_FFFF);

        // random: mostly loads, some multiplies, a little noise
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 2) begin
                marker.op    = OP_UNUSED;
                marker.row   = 2'd0;
                marker.col   = 2'd0;
                marker.value = '0;
                marker.drain = 1'b1;
                pending_requests.push_back(marker);
            end
            r = $urandom;
            case ($urandom_range(3))
                0: v = $urandom;
                1: v = {{14{r[17]}}, r[17:0]};
                2: begin
                    pick = $urandom_range(3);
                    v = (pick == 0) ? 32'h7FFF_FFFF : (pick == 1) ? 32'h8000_0000 :
                        (pick == 2) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                end
                default: v = {{8{r[23]}}, r[23:0]};
            endcase
            pick = $urandom_range(99);
            if (pick < 10)
                add_request(OP_MULTIPLY, 2'($urandom), 2'($urandom), $urandom);
            else if (pick < 15)
                add_request(OP_UNUSED, 2'($urandom), 2'($urandom), $urandom);
            else
                add_request((pick < 57) ? OP_LOAD_A : OP_LOAD_B,
                            2'($urandom), 2'($urandom), v);
        end

        // hold synchronous reset, then release it
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // wait for every request to go in and every result to come out
        while (pending_requests.size() != 0 || s_valid)
            @(posedge i_clk);
        while (expected_products.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0)
            $display("** matrix4x4_multiply: PASSED **");
        else
            $display("** matrix4x4_multiply: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
src/mat4mul_pkg.sv
src/mat4mul_store.sv
src/mat4mul_mac.sv
src/matrix4x4_multiply.sv
test/tb_matrix4x4_multiply.sv
